// ----- design/stt_pkg.sv -----
package stt_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int TOKEN_BITS  = 32;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAD_W     = M_TDATA_W - KIND_W - 2 * TOKEN_BITS;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_LITERAL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STRING  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LBEGIN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEND    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNTERM  = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CHAR_RBRACKET = 8'h5D;
    localparam logic [BYTE_W-1:0] CHAR_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_HASH     = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE    = 8'h20;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [TOKEN_BITS-1:0] start;
        logic [TOKEN_BITS-1:0] length;
        logic                  last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok1;
        token_t     tok0;
    } scan_result_t;

endpackage

// ----- design/stt_scanner.sv -----
module stt_scanner
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [stt_pkg::BYTE_W-1:0]     text_byte,
    input  logic                           end_of_text,
    output stt_pkg::scan_result_t          result
);
    import stt_pkg::*;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_LITERAL = 2'd3;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    logic [1:0]             mode_reg;
    logic [1:0]             mode_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [OFFSET_BITS-1:0] origin_reg;
    logic [OFFSET_BITS-1:0] origin_next;

    logic                   is_space;
    logic                   ends_literal;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] span_len;
    logic                   open_en;
    logic                   bracket_hit;
    token_t                 bracket_tok;
    token_t                 tok0;
    token_t                 tok1;
    logic [1:0]             n;

    function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                          input logic [OFFSET_BITS-1:0] start,
                                          input logic [OFFSET_BITS-1:0] len);
        logic [63:0] s64;
        logic [63:0] l64;
        token_t      t;
        s64      = 64'(start);
        l64      = 64'(len);
        t.kind   = kind;
        t.start  = s64[TOKEN_BITS-1:0];
        t.length = l64[TOKEN_BITS-1:0];
        t.last   = 1'b0;
        return t;
    endfunction

    assign is_space = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB)
                   || (text_byte == CHAR_CR) || (text_byte == CHAR_NEWLINE);

    assign ends_literal = is_space || (text_byte == CHAR_LBRACKET)
                       || (text_byte == CHAR_RBRACKET) || (text_byte == CHAR_COMMA)
                       || (text_byte == CHAR_HASH) || (text_byte == CHAR_QUOTE);

    assign pos_inc  = (pos_reg == OFFSET_MAX) ? pos_reg : pos_reg + 1'b1;
    assign span_len = (pos_reg >= origin_reg) ? pos_reg - origin_reg : '0;

    assign bracket_hit = (text_byte == CHAR_LBRACKET) || (text_byte == CHAR_RBRACKET);
    assign bracket_tok = make_token((text_byte == CHAR_LBRACKET) ? KIND_LBEGIN : KIND_LEND,
                                    pos_reg, OFFSET_BITS'(1));

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        origin_next = origin_reg;
        tok0        = '0;
        tok1        = '0;
        n           = 2'd0;
        open_en     = 1'b0;

        if (end_of_text)
        begin
            if (mode_reg == MODE_LITERAL)
            begin
                tok0 = make_token(KIND_LITERAL, origin_reg, span_len);
                tok1 = make_token(KIND_END, pos_reg, '0);
                n    = 2'd2;
            end
            else if (mode_reg == MODE_STRING)
            begin
                tok0 = make_token(KIND_UNTERM, origin_reg, '0);
                n    = 2'd1;
            end
            else
            begin
                tok0 = make_token(KIND_END, pos_reg, '0);
                n    = 2'd1;
            end
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            origin_next = '0;
        end
        else
        begin
            pos_next = pos_inc;
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (text_byte == CHAR_NEWLINE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    if (text_byte == CHAR_QUOTE)
                    begin
                        tok0      = make_token(KIND_STRING, origin_reg, span_len);
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_LITERAL:
                begin
                    if (ends_literal)
                    begin
                        tok0      = make_token(KIND_LITERAL, origin_reg, span_len);
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                        open_en   = 1'b1;
                    end
                end
                default:
                begin
                    open_en = 1'b1;
                end
            endcase

            // The byte that closed a literal may itself open the next token.
            if (open_en && !is_space)
            begin
                if (text_byte == CHAR_HASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (text_byte == CHAR_QUOTE)
                begin
                    mode_next   = MODE_STRING;
                    origin_next = pos_inc;
                end
                else if (bracket_hit)
                begin
                    if (n == 2'd0)
                    begin
                        tok0 = bracket_tok;
                    end
                    else
                    begin
                        tok1 = bracket_tok;
                    end
                    n = n + 2'd1;
                end
                else
                begin
                    mode_next   = MODE_LITERAL;
                    origin_next = pos_reg;
                end
            end
        end

        if (n == 2'd1)
        begin
            tok0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            tok1.last = 1'b1;
        end
    end

    assign result.count = n;
    assign result.tok0  = tok0;
    assign result.tok1  = tok1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            origin_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            origin_reg <= origin_next;
        end
    end

endmodule

// ----- design/stt_out_queue.sv -----
module stt_out_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  stt_pkg::scan_result_t result,
    output logic                  space_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output stt_pkg::token_t       head
);
    import stt_pkg::*;

    token_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [1:0]            push_n;
    logic                  pop;

    assign push_n    = push ? result.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= result.tok0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= result.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/scene_text_tokenizer_top.sv -----
// Scene text tokenizer.
// The slave stream carries one text byte per transfer in s_tdata; a transfer
// with s_tlast high is the end-of-text mark and its data is ignored. The
// master stream carries one token per transfer: kind, start offset and length
// in m_tdata, and m_tlast high on the final token caused by one input transfer.
// Each accepted byte is scanned in the cycle it is taken, and its tokens are
// written to a four-entry output queue, so a token can reach the master side
// in the cycle after the byte that caused it, at the earliest. One byte is taken
// every cycle while the queue has room for two tokens. A byte that closes a
// literal with a bracket, and an end mark inside a literal, give two tokens,
// which leave as two transfers. When the receiver stalls, the queue fills and
// s_tready drops until at least two entries are free again.
// Reset clears the scan mode, the byte offset, the token origin and the queue;
// after an end mark the scanner returns to the same state for the next text.
module scene_text_tokenizer_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stt_pkg::S_TDATA_W-1:0]   s_tdata,  // text_byte
    input  logic                            s_tlast,  // end_of_text
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stt_pkg::M_TDATA_W-1:0]   m_tdata,  // token_kind, token_start, token_length
    output logic                            m_tlast   // last_result
);
    import stt_pkg::*;

    logic         accept;
    logic         space_ok;
    scan_result_t result;
    token_t       head;

    assign s_tready = space_ok;
    assign accept   = s_tvalid && s_tready;

    stt_scanner u_scanner
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_tdata[BYTE_W-1:0]),
        .end_of_text (s_tlast),
        .result      (result)
    );

    stt_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .result    (result),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, head.length, head.start, head.kind};
    assign m_tlast = head.last;

endmodule

// ----- design/stt_checker.sv -----
module stt_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [stt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import stt_pkg::*;

    // A stalled token stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("token withdrawn while stalled");

    // An accepted end mark is always followed by a valid token on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("end mark produced no token");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[KIND_W-1:0] <= KIND_UNTERM)
                     && (m_tdata[M_TDATA_W-1 -: M_PAD_W] == '0))
        else $error("bad token kind or padding");

    // End and unterminated-string tokens have zero length and close their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[KIND_W-1:0] == KIND_END) || (m_tdata[KIND_W-1:0] == KIND_UNTERM))
            |-> (m_tdata[KIND_W + TOKEN_BITS +: TOKEN_BITS] == '0) && m_tlast)
        else $error("end token has length or is not last");

endmodule

bind scene_text_tokenizer_top stt_checker u_stt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
